/* rtl/core/ebnr_pkg.sv */
// Package: widths, CORDIC table and shared helpers for the Euler rotation unit.
`default_nettype none
package ebnr_pkg;
  localparam int CordicSteps   = 16;
  localparam int CompBits      = 32;
  localparam int AngleBits     = 16;
  localparam int TrigBits      = 32;   // Q2.30 plus sign headroom
  localparam int CordicBits    = 34;
  localparam logic signed [CordicBits-1:0] CordicGain = 34'sh026DD3B6A;
  localparam logic signed [TrigBits-1:0]   OneQ30     = 32'sh40000000;

  typedef logic signed [TrigBits-1:0] trig_t;

  typedef struct packed {
    logic signed [CompBits-1:0]  x;
    logic signed [CompBits-1:0]  y;
    logic signed [CompBits-1:0]  z;
    logic signed [AngleBits-1:0] roll;
    logic signed [AngleBits-1:0] pitch;
    logic signed [AngleBits-1:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [CompBits-1:0] x;
    logic signed [CompBits-1:0] y;
    logic signed [CompBits-1:0] z;
    logic                       clipped;
  } out_item_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } sc_t;

  // pipeline stall control shared by the stages
  typedef struct packed {
    logic advance;
  } pipe_ctl_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
      15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
      21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  function automatic trig_t clamp_unit(input logic signed [63:0] v);
    trig_t r;
    if (v > 64'sd1073741824) r = OneQ30;
    else if (v < -64'sd1073741824) r = -OneQ30;
    else r = trig_t'(v);
    return r;
  endfunction

  // Q2.30 product, rounded half up
  function automatic logic signed [33:0] mul30(input trig_t a, input trig_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 34'(p >>> 30);
  endfunction
endpackage
`default_nettype wire

/* rtl/core/ebnr_stream_if.sv */
// Interfaces: valid/ready channels for input and result transactions.
`default_nettype none
interface ebnr_in_if;
  import ebnr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ebnr_out_if;
  import ebnr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/ebnr_cordic.sv */
// Unrolled, pipelined CORDIC: one micro-rotation per register stage.
`default_nettype none
module ebnr_cordic
  import ebnr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire pipe_ctl_t            ctl_i,
  input  wire logic [AngleBits-1:0] angle_i,
  output sc_t                       sc_o
);
  logic signed [CordicBits-1:0] x_q [CordicSteps+1];
  logic signed [CordicBits-1:0] y_q [CordicSteps+1];
  logic signed [32:0]           z_q [CordicSteps+1];
  logic                         f_q [CordicSteps+1];

  logic [31:0] phase, phase_f;
  logic [1:0]  quad;
  logic        flip;
  always_comb begin
    phase   = {angle_i, {(32-AngleBits){1'b0}}};
    quad    = phase[31:30];
    flip    = (quad == 2'd1) || (quad == 2'd2);
    phase_f = flip ? phase + 32'h80000000 : phase;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      x_q[0] <= CordicGain;
      y_q[0] <= '0;
      z_q[0] <= {phase_f[31], phase_f};
      f_q[0] <= flip;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [CordicBits-1:0] dx, dy;
    logic signed [32:0]           at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = {1'b0, atan_entry(i)};
    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        f_q[i+1] <= f_q[i];
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  trig_t cx, sy;
  assign cx = clamp_unit(64'(x_q[CordicSteps]));
  assign sy = clamp_unit(64'(y_q[CordicSteps]));
  assign sc_o.c = f_q[CordicSteps] ? -cx : cx;
  assign sc_o.s = f_q[CordicSteps] ? -sy : sy;
endmodule
`default_nettype wire

/* rtl/core/ebnr_matrix.sv */
// Direction cosine matrix from sines and cosines, two register stages.
`default_nettype none
module ebnr_matrix
  import ebnr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire pipe_ctl_t ctl_i,
  input  wire sc_t       roll_i,
  input  wire sc_t       pitch_i,
  input  wire sc_t       yaw_i,
  output trig_t          m_o [9]
);
  // stage A: single products
  trig_t srsp_q, crsp_q, cpcy_q, crsy_q, cpsy_q, crcy_q, srcy_q, srsy_q;
  trig_t nsp_q, srcp_q, crcp_q, cy_q, sy_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      srsp_q <= trig_t'(mul30(roll_i.s, pitch_i.s));
      crsp_q <= trig_t'(mul30(roll_i.c, pitch_i.s));
      cpcy_q <= trig_t'(mul30(pitch_i.c, yaw_i.c));
      cpsy_q <= trig_t'(mul30(pitch_i.c, yaw_i.s));
      crsy_q <= trig_t'(mul30(roll_i.c, yaw_i.s));
      crcy_q <= trig_t'(mul30(roll_i.c, yaw_i.c));
      srcy_q <= trig_t'(mul30(roll_i.s, yaw_i.c));
      srsy_q <= trig_t'(mul30(roll_i.s, yaw_i.s));
      nsp_q  <= -pitch_i.s;
      srcp_q <= trig_t'(mul30(roll_i.s, pitch_i.c));
      crcp_q <= trig_t'(mul30(roll_i.c, pitch_i.c));
      cy_q   <= yaw_i.c;
      sy_q   <= yaw_i.s;
    end
  end
  // stage B: second products and sums, then clamp
  logic signed [33:0] e01, e02, e11, e12;
  assign e01 = 34'(mul30(srsp_q, cy_q)) - 34'(crsy_q);
  assign e02 = 34'(mul30(crsp_q, cy_q)) + 34'(srsy_q);
  assign e11 = 34'(mul30(srsp_q, sy_q)) + 34'(crcy_q);
  assign e12 = 34'(mul30(crsp_q, sy_q)) - 34'(srcy_q);
  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      m_o[0] <= clamp_unit(64'(cpcy_q));
      m_o[1] <= clamp_unit(64'(e01));
      m_o[2] <= clamp_unit(64'(e02));
      m_o[3] <= clamp_unit(64'(cpsy_q));
      m_o[4] <= clamp_unit(64'(e11));
      m_o[5] <= clamp_unit(64'(e12));
      m_o[6] <= clamp_unit(64'(nsp_q));
      m_o[7] <= clamp_unit(64'(srcp_q));
      m_o[8] <= clamp_unit(64'(crcp_q));
    end
  end
endmodule
`default_nettype wire

/* rtl/core/ebnr_rotate.sv */
// Matrix-vector product with rounding and saturation, three register stages.
`default_nettype none
module ebnr_rotate
  import ebnr_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire pipe_ctl_t                  ctl_i,
  input  wire trig_t                      m_i [9],
  input  wire logic signed [CompBits-1:0] v_i [3],
  output out_item_t                       res_o
);
  localparam int PW = CompBits + TrigBits;
  localparam int SW = PW + 2;
  logic signed [PW-1:0] p_q [9];
  logic signed [SW-1:0] s_q [3];

  for (genvar k = 0; k < 9; k++) begin : g_mul
    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) p_q[k] <= PW'(m_i[k]) * PW'(v_i[k%3]);
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_sum
    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        s_q[j] <= SW'(p_q[3*j]) + SW'(p_q[3*j+1]) + SW'(p_q[3*j+2])
                  + SW'(64'sd536870912);
      end
    end
  end

  localparam logic signed [SW-31:0] MaxV = (SW-30)'({1'b0, {(CompBits-1){1'b1}}});
  localparam logic signed [SW-31:0] MinV = -MaxV - (SW-30)'(1);
  logic signed [SW-31:0] r [3];
  logic [2:0] sat;
  logic signed [CompBits-1:0] o [3];
  for (genvar j = 0; j < 3; j++) begin : g_sat
    assign r[j]   = s_q[j][SW-1:30];
    assign sat[j] = (r[j] > MaxV) || (r[j] < MinV);
    assign o[j]   = (r[j] > MaxV) ? CompBits'(MaxV) :
                    (r[j] < MinV) ? CompBits'(MinV) : CompBits'(r[j]);
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      res_o.x       <= o[0];
      res_o.y       <= o[1];
      res_o.z       <= o[2];
      res_o.clipped <= |sat;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/euler_body_to_nav_rotation_unit.sv */
// Top level: Euler ZYX body-to-NED rotation pipeline.
//
//  channel  dir  payload
//  in_s     in   body_x/y/z Q16.16, roll/pitch/heading binary angles
//  out_m    out  nav_x/y/z Q16.16 saturated, clipped flag
//
// One transaction per cycle unless the full result register is not taken. The
// pipeline is the CORDIC input register and CordicSteps stages, two matrix
// stages, three product/sum/saturate stages.
// Reset clears only the valid bits. The whole pipeline holds when the
// result register is full and not taken; nothing is lost or repeated.
`default_nettype none
module euler_body_to_nav_rotation_unit
  import ebnr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ebnr_in_if.sink      in_s,
  ebnr_out_if.source   out_m
);
  localparam int Lat = CordicSteps + 1 + 2 + 3;
  logic [Lat-1:0] vld_q;
  pipe_ctl_t ctl;
  assign ctl.advance = !vld_q[Lat-1] || out_m.ready;
  assign in_s.ready  = ctl.advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (ctl.advance) vld_q <= {vld_q[Lat-2:0], in_s.valid};
  end

  sc_t sc_r, sc_p, sc_y;
  ebnr_cordic u_roll  (.clk_i, .ctl_i(ctl), .angle_i(in_s.data.roll),    .sc_o(sc_r));
  ebnr_cordic u_pitch (.clk_i, .ctl_i(ctl), .angle_i(in_s.data.pitch),   .sc_o(sc_p));
  ebnr_cordic u_yaw   (.clk_i, .ctl_i(ctl), .angle_i(in_s.data.heading), .sc_o(sc_y));

  // vector delay to line up with the matrix
  localparam int VD = CordicSteps + 3;
  logic signed [CompBits-1:0] vx_q [VD], vy_q [VD], vz_q [VD];
  always_ff @(posedge clk_i) begin
    if (ctl.advance) begin
      vx_q[0] <= in_s.data.x;
      vy_q[0] <= in_s.data.y;
      vz_q[0] <= in_s.data.z;
      for (int i = 1; i < VD; i++) begin
        vx_q[i] <= vx_q[i-1];
        vy_q[i] <= vy_q[i-1];
        vz_q[i] <= vz_q[i-1];
      end
    end
  end

  trig_t m [9];
  ebnr_matrix u_mat (.clk_i, .ctl_i(ctl), .roll_i(sc_r), .pitch_i(sc_p),
                     .yaw_i(sc_y), .m_o(m));

  logic signed [CompBits-1:0] v [3];
  assign v[0] = vx_q[VD-1];
  assign v[1] = vy_q[VD-1];
  assign v[2] = vz_q[VD-1];

  ebnr_rotate u_rot (.clk_i, .ctl_i(ctl), .m_i(m), .v_i(v), .res_o(out_m.data));
  assign out_m.valid = vld_q[Lat-1];

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && !out_m.ready |=> out_m.valid && $stable(out_m.data))
    else $error("result changed under stall");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_m.valid |-> in_s.ready)
    else $error("input stalled with empty output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_s.valid && in_s.ready |=> vld_q[0])
    else $error("accepted transaction lost");
`endif
endmodule
`default_nettype wire

/* test/tb_euler_body_to_nav_rotation_unit.sv */
// Testbench: random and directed body vectors and angles checked against a ZYX rotation predictor.
module tb_euler_body_to_nav_rotation_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ebnr_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 40;
  localparam int NumRandom     = 600;

  logic clk_i;
  logic rst_ni;

  ebnr_in_if  in_s ();
  ebnr_out_if out_m ();

  euler_body_to_nav_rotation_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_s),
    .out_m  (out_m)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  in_item_t  pending_q[$];
  out_item_t nav_expected_q[$];
  int        mismatches;
  int        idle_cycles;
  bit        stimulus_done;

  // rounded Q2.30 product, arithmetic shift floors
  function automatic logic signed [63:0] q30_mul(logic signed [63:0] a, logic signed [63:0] b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [63:0] unit_clamp(logic signed [63:0] v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic void angle_sin_cos(input logic [AngleBits-1:0] ang,
                                        output logic signed [63:0] c,
                                        output logic signed [63:0] s);
    logic [31:0]        phase;
    logic               flip;
    logic signed [63:0] x, y, z, dx, dy;
    phase = {ang, {(32-AngleBits){1'b0}}};
    flip  = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    if (flip) phase = phase + 32'h80000000;
    x = 64'sh26DD3B6A;  // CORDIC gain
    y = 0;
    z = 64'(signed'(phase));
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - 64'(atan_entry(i));
      end else begin
        x = x + dx; y = y - dy; z = z + 64'(atan_entry(i));
      end
    end
    x = unit_clamp(x);
    y = unit_clamp(y);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic out_item_t rotate_to_nav(in_item_t it);
    logic signed [63:0]  cr, sr, cp, sp, cy, sy;
    logic signed [63:0]  m[3][3];
    logic signed [63:0]  v[3];
    logic signed [127:0] acc;
    logic signed [63:0]  r[3];
    logic signed [63:0]  maxv, minv;
    out_item_t           o;
    angle_sin_cos(it.roll, cr, sr);
    angle_sin_cos(it.pitch, cp, sp);
    angle_sin_cos(it.heading, cy, sy);
    v[0] = it.x; v[1] = it.y; v[2] = it.z;
    m[0][0] = q30_mul(cp, cy);
    m[0][1] = -q30_mul(cr, sy) + q30_mul(q30_mul(sr, sp), cy);
    m[0][2] = q30_mul(q30_mul(cr, sp), cy) + q30_mul(sr, sy);
    m[1][0] = q30_mul(cp, sy);
    m[1][1] = q30_mul(cr, cy) + q30_mul(q30_mul(sr, sp), sy);
    m[1][2] = q30_mul(q30_mul(cr, sp), sy) - q30_mul(sr, cy);
    m[2][0] = -sp;
    m[2][1] = q30_mul(sr, cp);
    m[2][2] = q30_mul(cr, cp);
    maxv = (64'sd1 <<< (CompBits-1)) - 1;
    minv = -maxv - 1;
    o.clipped = 1'b0;
    for (int j = 0; j < 3; j++) begin
      acc = 128'sd536870912;
      for (int k = 0; k < 3; k++) acc = acc + 128'(unit_clamp(m[j][k])) * 128'(v[k]);
      acc = acc >>> 30;
      if (acc > 128'(maxv)) begin
        r[j] = maxv; o.clipped = 1'b1;
      end else if (acc < 128'(minv)) begin
        r[j] = minv; o.clipped = 1'b1;
      end else begin
        r[j] = 64'(acc);
      end
    end
    o.x = r[0][CompBits-1:0];
    o.y = r[1][CompBits-1:0];
    o.z = r[2][CompBits-1:0];
    return o;
  endfunction

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  // input transaction taken at the rising edge, consumed by the driver
  bit in_taken;
  always @(posedge clk_i) in_taken <= rst_ni && in_s.valid && in_s.ready;

  // driver: next transaction presented after a random gap, changes at falling edge
  int send_gap;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_s.valid <= 1'b0;
    end else if (in_s.valid && !in_taken) begin
      // hold
    end else begin
      if (in_taken) begin
        nav_expected_q.push_back(rotate_to_nav(in_s.data));
        void'(pending_q.pop_front());
        send_gap = gap_length();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_s.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_s.valid <= 1'b1;
        in_s.data  <= pending_q[0];
      end else begin
        in_s.valid <= 1'b0;
      end
    end
  end

  // ready of the sink: random stalls, some long stretches without any
  int stall_left;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_m.ready <= 1'b0;
    end else begin
      out_m.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = gap_length();
    end
  end

  // monitor: samples at the rising edge
  out_item_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_m.valid && out_m.ready) begin
      if (nav_expected_q.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        mismatches++;
      end else begin
        want = nav_expected_q.pop_front();
        if (out_m.data.x !== want.x) report_mismatch("nav_x", out_m.data.x, want.x);
        if (out_m.data.y !== want.y) report_mismatch("nav_y", out_m.data.y, want.y);
        if (out_m.data.z !== want.z) report_mismatch("nav_z", out_m.data.z, want.z);
        if (out_m.data.clipped !== want.clipped)
          report_mismatch("clipped", 32'(out_m.data.clipped), 32'(want.clipped));
      end
    end
  end

  // watchdog on accepted transactions on either side
  always @(posedge clk_i) begin
    if ((in_s.valid && in_s.ready) || (out_m.valid && out_m.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("[euler_body_to_nav_rotation_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_component();
    case ($urandom_range(0, 5))
      0:       return 32'($urandom_range(0, 131072)) - 32'd65536;  // within +/-1.0
      1:       return {{14{1'b0}}, 18'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
      2:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 3)) << 14;  // quadrant boundaries
      1:       return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_item(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [15:0] rl, logic [15:0] pt, logic [15:0] hd);
    in_item_t it;
    it.x = x; it.y = y; it.z = z;
    it.roll = rl; it.pitch = pt; it.heading = hd;
    pending_q.push_back(it);
  endtask

  initial begin
    logic [15:0] corner_angles[6];
    corner_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h3FFF};
    rst_ni        = 1'b0;
    in_s.valid    = 1'b0;
    in_s.data     = '0;
    out_m.ready   = 1'b0;
    mismatches    = 0;
    idle_cycles   = 0;
    send_gap      = 0;
    stall_left    = 0;
    stimulus_done = 1'b0;

    // directed: zero vector, unit components, extremes that clip, quadrant folds per angle
    add_item(0, 0, 0, 0, 0, 0);
    add_item(32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0);
    add_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h1000, 16'h1000, 16'h1000);
    add_item(32'h80000000, 32'h80000000, 32'h80000000, 16'h1000, 16'h1000, 16'h1000);
    add_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
    add_item(32'hFFFFFFFF, 32'h00000001, 32'hFFFF0000, 16'h2000, 16'hE000, 16'h6000);
    foreach (corner_angles[i]) begin
      add_item(32'h00010000, 32'h00020000, 32'hFFFD0000, corner_angles[i], 0, 0);
      add_item(32'h00010000, 32'h00020000, 32'hFFFD0000, 0, corner_angles[i], 0);
      add_item(32'h00010000, 32'h00020000, 32'hFFFD0000, 0, 0, corner_angles[i]);
    end

    repeat (NumRandom)
      add_item(rand_component(), rand_component(), rand_component(),
               rand_angle(), rand_angle(), rand_angle());

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_q.size() == 0 && !in_s.valid);
    wait (nav_expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && nav_expected_q.size() == 0) begin
      $display("[euler_body_to_nav_rotation_unit] OK");
    end else begin
      $display("[euler_body_to_nav_rotation_unit] ERROR");
    end
    $finish;
  end
endmodule
